// ----- design/hvd_pkg.sv -----
package hvd_pkg;

  // Field widths fixed by the external interface.
  localparam int HEAD_W   = 15;
  localparam int TREND_W  = 8;
  localparam int VOTE_W   = 8;
  localparam int SECTORS  = 8;
  localparam int SECT_W   = 3;

  // Defaults for the top-level parameters.
  localparam int CORDIC_ITERATIONS_DEF = 14;
  localparam int ANGLE_FRAC_BITS_DEF   = 12;

  // Reset value of the vote limit register.
  localparam logic [VOTE_W-1:0] LIMIT_RESET = 8'd10;

  // Datapath widths of the vectoring unit.
  localparam int XY_W       = 38;
  localparam int Z_W        = 34;
  localparam int ITER_IDX_W = 5;
  localparam int UNIT_SHIFT = 24;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint RT_HALF_Q24 = 64'sd11863283;

  // Packed bank of the eight sector counters.
  typedef logic [SECTORS-1:0][VOTE_W-1:0] vote_arr_t;

  // Commands from the sequencer to the vote bank.
  typedef struct packed {
    logic              update;
    logic              decay;
    logic              rise;
    logic              fall;
    logic [SECT_W-1:0] sector;
  } vote_ctl_t;

  // Commands from the sequencer to the vectoring unit.
  typedef struct packed {
    logic                  load;
    logic                  pre;
    logic                  iter;
    logic [ITER_IDX_W-1:0] idx;
  } cordic_ctl_t;

  // Sector bound m*pi/8 with the given fraction bits, rounded to nearest.
  function automatic longint sector_bound(input int m, input int frac);
    longint v;
    int     s;
    s = 33 - frac;
    v = longint'(m) * PI_Q30 + (longint'(1) <<< (s - 1));
    return v >>> s;
  endfunction

  // Arctangent of 2^-i in radians with 30 fraction bits.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ITER_IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      5'd11:   r = 34'sd524288;
      5'd12:   r = 34'sd262144;
      5'd13:   r = 34'sd131072;
      5'd14:   r = 34'sd65536;
      5'd15:   r = 34'sd32768;
      5'd16:   r = 34'sd16384;
      5'd17:   r = 34'sd8192;
      5'd18:   r = 34'sd4096;
      5'd19:   r = 34'sd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/hvd_if.sv -----
// Input item channel: beacon heading and signal trend.
interface hvd_item_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hvd_pkg::HEAD_W-1:0]    beacon_heading;
  logic signed [hvd_pkg::TREND_W-1:0]   signal_trend;

  modport source (output valid, output beacon_heading, output signal_trend, input ready);
  modport sink   (input valid, input beacon_heading, input signal_trend, output ready);
endinterface

// Result channel: estimated heading and vote presence flag.
interface hvd_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hvd_pkg::HEAD_W-1:0]    estimated_heading;
  logic                                 votes_present;

  modport source (output valid, output estimated_heading, output votes_present, input ready);
  modport sink   (input valid, input estimated_heading, input votes_present, output ready);
endinterface

// Configuration write channel for the vote limit register.
interface hvd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [hvd_pkg::VOTE_W-1:0]           vote_limit;

  modport source (output valid, output vote_limit, input ready);
  modport sink   (input valid, input vote_limit, output ready);
endinterface

// ----- design/heading_vote_direction_estimator.sv -----
// An accepted input transaction steps through the update, decay, sum, pre-rotation,
// iteration and finish states before its result is registered; a new item is taken
// only once the sequencer is back in idle. The single shared vectoring unit runs one
// micro-rotation per cycle.
// Reset (synchronous, active high) clears all sector counters, sets the vote limit to 10
// and empties the result register.
module heading_vote_direction_estimator #(
  parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS   = hvd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hvd_cfg_if.sink       cfg,
  hvd_item_if.sink      item,
  hvd_result_if.source  result
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UPDATE = 7'b0000010,
    ST_DECAY  = 7'b0000100,
    ST_SUM    = 7'b0001000,
    ST_PRE    = 7'b0010000,
    ST_ITER   = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  localparam logic [hvd_pkg::ITER_IDX_W-1:0] LAST_IDX =
    hvd_pkg::ITER_IDX_W'(CORDIC_ITERATIONS - 1);

  state_t state, state_next;
  logic [hvd_pkg::ITER_IDX_W-1:0] idx;
  logic [hvd_pkg::VOTE_W-1:0] vote_limit;

  logic signed [hvd_pkg::HEAD_W-1:0]  heading;
  logic signed [hvd_pkg::TREND_W-1:0] trend;

  logic signed [31:0] hext;
  logic [6:0]         ge;
  logic               below;
  logic [hvd_pkg::SECT_W-1:0] sector;

  hvd_pkg::vote_ctl_t   vctl;
  hvd_pkg::cordic_ctl_t cctl;
  hvd_pkg::vote_arr_t   votes;
  logic                 any;
  logic signed [hvd_pkg::HEAD_W-1:0] angle;
  logic                 out_free;

  // Configuration register, always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_limit <= hvd_pkg::LIMIT_RESET;
    end else if (cfg.valid) begin
      vote_limit <= cfg.vote_limit;
    end
  end

  // Capture the input transaction.
  assign item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      heading <= item.beacon_heading;
      trend   <= item.signal_trend;
    end
  end

  // Sector of the heading against odd multiples of pi/8.
  always_comb begin
    hext  = 32'(heading);
    below = hext < 32'(hvd_pkg::sector_bound(-7, ANGLE_FRAC_BITS));
    for (int k = 0; k < 7; k++) begin
      ge[k] = hext >= 32'(hvd_pkg::sector_bound(2 * k - 5, ANGLE_FRAC_BITS));
    end
    sector = '0;
    for (int k = 0; k < 7; k++) begin
      sector = sector + hvd_pkg::SECT_W'(ge[k]);
    end
    if (below) begin
      sector = 3'd7;
    end
  end

  // Commands to the vote bank and the vectoring unit.
  always_comb begin
    vctl.update = (state == ST_UPDATE);
    vctl.decay  = (state == ST_DECAY);
    vctl.rise   = (trend != '0) && !trend[hvd_pkg::TREND_W-1];
    vctl.fall   = trend[hvd_pkg::TREND_W-1];
    vctl.sector = sector;
    cctl.load   = (state == ST_SUM);
    cctl.pre    = (state == ST_PRE);
    cctl.iter   = (state == ST_ITER);
    cctl.idx    = idx;
  end

  assign out_free = !result.valid || result.ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (item.valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DECAY;
      ST_DECAY:  state_next = ST_SUM;
      ST_SUM:    state_next = ST_PRE;
      ST_PRE:    state_next = ST_ITER;
      ST_ITER:   if (idx == LAST_IDX) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ITER) begin
        idx <= idx + hvd_pkg::ITER_IDX_W'(1);
      end else begin
        idx <= '0;
      end
    end
  end

  // Result register parts the output from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result.estimated_heading <= angle;
      result.votes_present     <= any;
    end
  end

  hvd_votes u_votes (
    .clk   (clk),
    .rst   (rst),
    .ctl   (vctl),
    .limit (vote_limit),
    .votes (votes),
    .any   (any)
  );

  hvd_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .ctl   (cctl),
    .votes (votes),
    .angle (angle)
  );

endmodule

// ----- design/hvd_votes.sv -----
module hvd_votes (
  input  logic                         clk,
  input  logic                         rst,
  input  hvd_pkg::vote_ctl_t           ctl,
  input  logic [hvd_pkg::VOTE_W-1:0]   limit,
  output hvd_pkg::vote_arr_t           votes,
  output logic                         any
);

  hvd_pkg::vote_arr_t votes_next;
  logic [hvd_pkg::SECT_W-1:0] opposite;
  logic [hvd_pkg::SECTORS-1:0] over;
  logic exceed;

  assign opposite = ctl.sector + 3'd4;

  // Any counter above the limit triggers a decay of all nonzero counters.
  always_comb begin
    for (int i = 0; i < hvd_pkg::SECTORS; i++) begin
      over[i] = votes[i] > limit;
    end
    exceed = |over;
  end

  // Per-counter next value: saturating vote update or decay.
  always_comb begin
    votes_next = votes;
    for (int i = 0; i < hvd_pkg::SECTORS; i++) begin
      if (ctl.update) begin
        if ((ctl.rise && ctl.sector == 3'(i)) || (ctl.fall && opposite == 3'(i))) begin
          if (votes[i] != 8'hFF) begin
            votes_next[i] = votes[i] + 8'd1;
          end
        end else if ((ctl.rise && opposite == 3'(i)) || (ctl.fall && ctl.sector == 3'(i))) begin
          if (votes[i] != 8'h00) begin
            votes_next[i] = votes[i] - 8'd1;
          end
        end
      end else if (ctl.decay && exceed) begin
        if (votes[i] != 8'h00) begin
          votes_next[i] = votes[i] - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      votes <= '0;
    end else begin
      votes <= votes_next;
    end
  end

  assign any = |votes;

endmodule

// ----- design/hvd_cordic.sv -----
module hvd_cordic #(
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  hvd_pkg::cordic_ctl_t               ctl,
  input  hvd_pkg::vote_arr_t                 votes,
  output logic signed [hvd_pkg::HEAD_W-1:0]  angle
);

  localparam int XW = hvd_pkg::XY_W;
  localparam int ZW = hvd_pkg::Z_W;
  localparam int RS = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [25:0] RT = 26'(hvd_pkg::RT_HALF_Q24);
  localparam logic signed [ZW:0] RND = (ZW+1)'(longint'(1) <<< (RS - 1));
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(hvd_pkg::HALF_PI_Q30);

  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic                 zero_vec;

  logic signed [9:0]  ax, ay;
  logic signed [10:0] bx, by;
  logic signed [35:0] px, py;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW:0]   zr, zsh;

  // Axis and diagonal vote differences of the weighted vector sum.
  always_comb begin
    ax = $signed({2'b00, votes[3]}) - $signed({2'b00, votes[7]});
    ay = $signed({2'b00, votes[5]}) - $signed({2'b00, votes[1]});
    bx = $signed({3'b000, votes[2]}) + $signed({3'b000, votes[4]})
       - $signed({3'b000, votes[0]}) - $signed({3'b000, votes[6]});
    by = $signed({3'b000, votes[4]}) + $signed({3'b000, votes[6]})
       - $signed({3'b000, votes[0]}) - $signed({3'b000, votes[2]});
    px = 36'(bx) * 36'(RT);
    py = 36'(by) * 36'(RT);
  end

  assign xs = x >>> ctl.idx;
  assign ys = y >>> ctl.idx;

  // Shared vectoring datapath: load, quadrant fold, then one micro-rotation a cycle.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= (XW'(ax) <<< hvd_pkg::UNIT_SHIFT) + XW'(px);
      y <= (XW'(ay) <<< hvd_pkg::UNIT_SHIFT) + XW'(py);
    end else if (ctl.pre) begin
      zero_vec <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          x <= y;
          y <= -x;
          z <= HALF_PI;
        end else begin
          x <= -y;
          y <= x;
          z <= -HALF_PI;
        end
      end else begin
        z <= '0;
      end
    end else if (ctl.iter) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + hvd_pkg::atan_q30(ctl.idx);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - hvd_pkg::atan_q30(ctl.idx);
      end
    end
  end

  // Round the angle to the output format, ties toward plus infinity.
  always_comb begin
    zr  = $signed({z[ZW-1], z}) + RND;
    zsh = zr >>> RS;
    angle = zero_vec ? '0 : zsh[hvd_pkg::HEAD_W-1:0];
  end

endmodule

// ----- design/hvd_checker.sv -----
module hvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [14:0] estimated_heading,
  input logic        votes_present
);

  // The block is busy in the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("input taken while a transaction is in progress");

  // Reset leaves the block ready with no pending result.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (item_ready && !result_valid))
    else $error("wrong state after reset");

  // With no votes the heading must be zero.
  a_no_votes_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !votes_present) |-> (estimated_heading == 15'd0))
    else $error("nonzero heading without votes");

  // A pending result holds until taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(estimated_heading) && $stable(votes_present)))
    else $error("pending result changed");

endmodule

bind heading_vote_direction_estimator hvd_checker u_hvd_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .estimated_heading (result.estimated_heading),
  .votes_present     (result.votes_present)
);

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC        = hvd_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int     ITERS       = hvd_pkg::CORDIC_ITERATIONS_DEF;
  localparam int     LATENCY     = hvd_pkg::CORDIC_ITERATIONS_DEF + 5;
  localparam longint UNIT_Q24    = 64'sd16777216;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     HOLD_AFTER  = 420;
  localparam int     HOLD_CYCLES = 150;

  typedef struct {
    logic signed [hvd_pkg::HEAD_W-1:0]  heading;
    logic signed [hvd_pkg::TREND_W-1:0] trend;
  } beacon_item_t;

  typedef struct {
    logic signed [hvd_pkg::HEAD_W-1:0] heading;
    logic                              present;
  } estimate_t;

  logic clk;
  logic rst;

  hvd_cfg_if    cfg_bus ();
  hvd_item_if   item_bus ();
  hvd_result_if result_bus ();

  heading_vote_direction_estimator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  // Arctangent of 2^-i in radians with 30 fraction bits.
  longint arctan_q30 [0:19] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048
  };

  // Predicted copy of the sector counters and the vote limit.
  logic [hvd_pkg::VOTE_W-1:0] tally [0:hvd_pkg::SECTORS-1];
  logic [hvd_pkg::VOTE_W-1:0] limit_now;

  beacon_item_t beacon_queue [$];
  estimate_t    estimate_queue [$];

  int  items_taken;
  int  estimates_checked;
  int  fail_count;
  int  limits_used;
  int  cycle_count;
  int  hold_left;
  bit  hold_done;
  bit  quiet;

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sector bound m*pi/8 in the heading format, rounded to nearest.
  function automatic longint pi8_bound(input int m);
    return ((longint'(m) * hvd_pkg::PI_Q30) + (longint'(1) <<< (32 - FRAC))) >>> (33 - FRAC);
  endfunction

  // Sector index of a heading; the sector around pi wraps at both ends.
  function automatic int heading_sector(input logic signed [hvd_pkg::HEAD_W-1:0] h);
    longint hv;
    int     idx;
    int     m;
    hv = h;
    if (hv < pi8_bound(-7)) return 7;
    idx = 0;
    for (m = -5; m <= 7; m += 2)
      if (hv >= pi8_bound(m)) idx++;
    return idx;
  endfunction

  // Applies one vote to the predicted counters and computes the heading estimate.
  function automatic estimate_t predict_estimate(input beacon_item_t it);
    estimate_t e;
    int        sec;
    int        opp;
    int        i;
    int        peak;
    bit        any;
    longint    vv [0:7];
    longint    x, y, z, xs, ys, t;
    sec = heading_sector(it.heading);
    opp = (sec + 4) % 8;
    if (it.trend > 0) begin
      if (tally[sec] != 8'd255) tally[sec] = tally[sec] + 8'd1;
      if (tally[opp] != 8'd0) tally[opp] = tally[opp] - 8'd1;
    end else if (it.trend < 0) begin
      if (tally[sec] != 8'd0) tally[sec] = tally[sec] - 8'd1;
      if (tally[opp] != 8'd255) tally[opp] = tally[opp] + 8'd1;
    end

    // Decay every nonzero counter once any counter goes past the limit.
    peak = 0;
    for (i = 0; i < hvd_pkg::SECTORS; i++)
      if (int'(tally[i]) > peak) peak = tally[i];
    if (peak > int'(limit_now))
      for (i = 0; i < hvd_pkg::SECTORS; i++)
        if (tally[i] != 8'd0) tally[i] = tally[i] - 8'd1;

    any = 1'b0;
    for (i = 0; i < hvd_pkg::SECTORS; i++) begin
      vv[i] = longint'(tally[i]);
      if (vv[i] != 0) any = 1'b1;
    end

    // Vote-weighted sum of the sector unit vectors.
    x = (vv[3] - vv[7]) * UNIT_Q24
      + (vv[2] + vv[4] - vv[0] - vv[6]) * hvd_pkg::RT_HALF_Q24;
    y = (vv[5] - vv[1]) * UNIT_Q24
      + (vv[4] + vv[6] - vv[0] - vv[2]) * hvd_pkg::RT_HALF_Q24;

    z = 0;
    if (any && (x != 0 || y != 0)) begin
      // Fold the left half plane onto the right one before rotating.
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = hvd_pkg::HALF_PI_Q30;
        end else begin
          x = -y;
          y = t;
          z = -hvd_pkg::HALF_PI_Q30;
        end
      end
      for (i = 0; i < ITERS && i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_q30[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_q30[i];
        end
      end
      z = (z + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
    end
    e.heading = z[hvd_pkg::HEAD_W-1:0];
    e.present = any;
    return e;
  endfunction

  // Item driver: offers queued beacon transactions with random gaps.
  always @(posedge clk) begin
    int           gap_left;
    beacon_item_t nxt;
    if (rst) begin
      item_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        nxt.heading = item_bus.beacon_heading;
        nxt.trend   = item_bus.signal_trend;
        estimate_queue.push_back(predict_estimate(nxt));
        items_taken <= items_taken + 1;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (gap_left == 0 && !quiet && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 8);
        if (gap_left > 0 || beacon_queue.size() == 0) begin
          item_bus.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          nxt = beacon_queue.pop_front();
          item_bus.valid          <= 1'b1;
          item_bus.beacon_heading <= nxt.heading;
          item_bus.signal_trend   <= nxt.trend;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result ready with random stall bursts.
  always @(posedge clk) begin
    int stall_left;
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= (hold_left == 0);
      end
    end
  end

  // Result monitor: compares each result transaction with the oldest estimate.
  always @(posedge clk) begin
    estimate_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (estimate_queue.size() == 0) begin
        if (fail_count < 10)
          $display("[%0t] unexpected result: heading %0d votes_present %0b", $realtime,
                   result_bus.estimated_heading, result_bus.votes_present);
        fail_count++;
      end else begin
        want = estimate_queue.pop_front();
        estimates_checked++;
        if (result_bus.estimated_heading !== want.heading ||
            result_bus.votes_present !== want.present) begin
          if (fail_count < 10)
            $display("[%0t] mismatch: heading exp %0d got %0d, votes_present exp %0b got %0b",
                     $realtime, want.heading, result_bus.estimated_heading,
                     want.present, result_bus.votes_present);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Waits until the block has drained, then lets it settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (beacon_queue.size() != 0 || item_bus.valid || estimate_queue.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // Writes the vote limit through the configuration channel.
  task automatic write_limit(input logic [hvd_pkg::VOTE_W-1:0] v);
    @(posedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.vote_limit <= v;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    limit_now = v;
    limits_used++;
  endtask

  // Queues random items: mostly a beacon held in one sector, the rest noise.
  task automatic queue_random(input int n, input bit stubborn);
    int           k;
    int           target;
    int           jit;
    longint       c;
    beacon_item_t it;
    target = $urandom_range(0, 7);
    for (k = 0; k < n; k++) begin
      if (!stubborn && $urandom_range(0, 39) == 0) target = $urandom_range(0, 7);
      if (stubborn || $urandom_range(0, 9) < 7) begin
        jit = $urandom_range(0, 3000) - 1500;
        c = (((longint'(target) - 3) * hvd_pkg::PI_Q30) >>> 20) + jit;
        if (c > 12868) c = c - 25736;
        it.heading = c[hvd_pkg::HEAD_W-1:0];
        if (stubborn || $urandom_range(0, 4) != 0)
          it.trend = hvd_pkg::TREND_W'($urandom_range(1, 127));
        else
          it.trend = hvd_pkg::TREND_W'($urandom);
      end else begin
        it.heading = hvd_pkg::HEAD_W'($urandom);
        it.trend   = hvd_pkg::TREND_W'($urandom);
      end
      beacon_queue.push_back(it);
    end
  endtask

  task automatic queue_item(input int h, input int tr);
    beacon_item_t it;
    it.heading = hvd_pkg::HEAD_W'(h);
    it.trend   = hvd_pkg::TREND_W'(tr);
    beacon_queue.push_back(it);
  endtask

  task automatic run_phase(input logic [hvd_pkg::VOTE_W-1:0] lim, input int n,
                           input bit stubborn);
    wait_idle();
    write_limit(lim);
    queue_random(n, stubborn);
  endtask

  // Stimulus sequence.
  initial begin
    int m;
    rst                       = 1'b1;
    item_bus.valid            = 1'b0;
    item_bus.beacon_heading   = '0;
    item_bus.signal_trend     = '0;
    cfg_bus.valid             = 1'b0;
    cfg_bus.vote_limit        = '0;
    result_bus.ready          = 1'b0;
    quiet                     = 1'b0;
    items_taken               = 0;
    estimates_checked         = 0;
    fail_count                = 0;
    limits_used               = 0;
    cycle_count               = 0;
    limit_now                 = hvd_pkg::LIMIT_RESET;
    for (m = 0; m < hvd_pkg::SECTORS; m++) tally[m] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset limit: trend extremes, zero trend,
    // heading extremes, out-of-range headings and both sides of every bound.
    queue_item(0, 127);
    queue_item(0, 0);
    queue_item(12868, 127);
    queue_item(-12868, -128);
    queue_item(-16384, 1);
    queue_item(16383, -1);
    for (m = -7; m <= 7; m += 2) begin
      queue_item(int'(pi8_bound(m)), 1);
      queue_item(int'(pi8_bound(m)) - 1, 64);
    end
    queue_item(-1, 5);
    queue_item(1, -5);

    // Random phases over several limits, the extremes among them.
    run_phase(8'd0, 80, 1'b0);
    run_phase(8'd255, 280, 1'b1);
    run_phase(8'd254, 120, 1'b0);
    run_phase(8'd1, 100, 1'b0);
    run_phase(hvd_pkg::VOTE_W'($urandom_range(2, 253)), 110, 1'b0);
    run_phase(hvd_pkg::VOTE_W'($urandom_range(2, 20)), 110, 1'b0);
    wait_idle();
    quiet <= 1'b1;
    run_phase(hvd_pkg::VOTE_W'($urandom_range(2, 253)), 130, 1'b0);
    wait_idle();

    $display("Checked %0d heading estimates from %0d beacon transactions", estimates_checked,
             items_taken);
    $display("over %0d vote limit writes, including 0, 254 and 255.", limits_used);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- heading_vote_direction_estimator.f -----
design/hvd_pkg.sv
design/hvd_if.sv
design/hvd_votes.sv
design/hvd_cordic.sv
design/heading_vote_direction_estimator.sv
design/hvd_checker.sv
bench/tb.sv
